// File: hw/rtl/i2cx_pkg.sv
`timescale 1ns / 1ps

package i2cx_pkg;

	// Configuration register indexes and reset values.
	typedef enum logic [1:0] {
		CFG_WR_ADDR = 2'd0,
		CFG_RD_ADDR = 2'd1,
		CFG_DELAY   = 2'd2
	} cfg_reg_t;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [7:0]  WR_ADDR_RESET = 8'd64;
	localparam logic [7:0]  RD_ADDR_RESET = 8'd65;
	localparam logic [15:0] DELAY_RESET   = 16'd100;

	localparam logic [7:0] SHADOW_RESET = 8'hFF;
	localparam logic [7:0] PIN_MAX      = 8'd7;
	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	typedef enum logic [1:0] {
		MODE_WRITE_ALL = 2'd0,
		MODE_SET_PIN   = 2'd1,
		MODE_READ_ALL  = 2'd2,
		MODE_READ_PIN  = 2'd3
	} mode_t;

	typedef enum logic [4:0] {
		PH_IDLE    = 5'd0,
		PH_ST_A    = 5'd1,
		PH_ST_B    = 5'd2,
		PH_TX1_LO  = 5'd3,
		PH_TX1_HI  = 5'd4,
		PH_ACK1_LO = 5'd5,
		PH_ACK1_HI = 5'd6,
		PH_TX2_LO  = 5'd7,
		PH_TX2_HI  = 5'd8,
		PH_ACK2_LO = 5'd9,
		PH_ACK2_HI = 5'd10,
		PH_RX_LO   = 5'd11,
		PH_RX_HI   = 5'd12,
		PH_MACK_LO = 5'd13,
		PH_MACK_HI = 5'd14,
		PH_SP_A    = 5'd15,
		PH_SP_B    = 5'd16,
		PH_SP_C    = 5'd17,
		PH_ABORT   = 5'd18
	} phase_t;

	typedef struct packed {
		logic [7:0]  write_address_byte;
		logic [7:0]  read_address_byte;
		logic [15:0] delay_ticks;
	} cfg_t;

	typedef struct packed {
		logic       cmd_valid;
		logic [1:0] mode;
		logic [7:0] pin_index;
		logic       pin_level;
		logic [7:0] write_byte;
		logic       sda_in;
	} cmd_item_t;

	typedef struct packed {
		logic       scl;
		logic       sda_out;
		logic       busy_res;
		logic       done_res;
		logic       ack_fail;
		logic [7:0] read_value;
		logic       pin_value;
		logic [7:0] port_image;
	} res_item_t;

endpackage

// File: hw/rtl/i2cx_stream_if.sv
`timescale 1ns / 1ps

interface i2cx_stream_if #(
	parameter type item_t = logic
);
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/i2cx_cfg.sv
`timescale 1ns / 1ps

module i2cx_cfg
	import i2cx_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.write_address_byte <= WR_ADDR_RESET;
			cfg_q.read_address_byte  <= RD_ADDR_RESET;
			cfg_q.delay_ticks        <= DELAY_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_WR_ADDR: cfg_q.write_address_byte <= cfg_wdata[7:0];
				CFG_RD_ADDR: cfg_q.read_address_byte  <= cfg_wdata[7:0];
				CFG_DELAY:   cfg_q.delay_ticks        <= cfg_wdata;
				default: begin
					// Writes beyond the register list are dropped.
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: hw/rtl/i2cx_seq.sv
`timescale 1ns / 1ps

module i2cx_seq
	import i2cx_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step_en,
	input  cfg_t      cfg,
	input  cmd_item_t cmd,
	output res_item_t res
);

	logic [7:0]  shadow_q, shadow_d;
	phase_t      phase_q, phase_d;
	logic [3:0]  bit_count_q, bit_count_d;
	logic [7:0]  shift_q, shift_d;
	logic [15:0] tick_q, tick_d;
	mode_t       mode_q, mode_d;
	logic [2:0]  pin_q, pin_d;
	logic [7:0]  pending_q, pending_d;
	logic        scl_q, scl_d;
	logic        sda_q, sda_d;

	logic [15:0] slot;
	logic        pin_ok;
	logic        go;
	phase_t      go_phase;
	logic        go_scl;
	logic        go_sda;
	logic        finish;
	logic        fail;

	assign slot   = (cfg.delay_ticks == '0) ? 16'd1 : cfg.delay_ticks;
	assign pin_ok = cmd.pin_index <= PIN_MAX;

	always_comb begin
		shadow_d    = shadow_q;
		phase_d     = phase_q;
		bit_count_d = bit_count_q;
		shift_d     = shift_q;
		tick_d      = tick_q;
		mode_d      = mode_q;
		pin_d       = pin_q;
		pending_d   = pending_q;
		scl_d       = scl_q;
		sda_d       = sda_q;
		go          = 1'b0;
		go_phase    = PH_IDLE;
		go_scl      = 1'b1;
		go_sda      = 1'b1;
		finish      = 1'b0;
		fail        = 1'b0;
		res         = '0;

		// Command start: only an idle master takes a command.
		if (phase_q == PH_IDLE && cmd.cmd_valid) begin
			unique case (mode_t'(cmd.mode))
				MODE_WRITE_ALL: begin
					mode_d    = MODE_WRITE_ALL;
					pin_d     = '0;
					pending_d = cmd.write_byte;
					phase_d   = PH_ST_A;
				end
				MODE_SET_PIN: begin
					if (pin_ok) begin
						shadow_d[cmd.pin_index[2:0]] = cmd.pin_level;
						mode_d    = MODE_SET_PIN;
						pin_d     = cmd.pin_index[2:0];
						pending_d = shadow_d;
						phase_d   = PH_ST_A;
					end
				end
				MODE_READ_ALL: begin
					mode_d  = MODE_READ_ALL;
					pin_d   = '0;
					phase_d = PH_ST_A;
				end
				MODE_READ_PIN: begin
					if (pin_ok) begin
						mode_d  = MODE_READ_PIN;
						pin_d   = cmd.pin_index[2:0];
						phase_d = PH_ST_A;
					end else begin
						res.done_res = 1'b1;
					end
				end
			endcase
			if (phase_d == PH_ST_A) begin
				scl_d  = 1'b1;
				sda_d  = 1'b1;
				tick_d = '0;
			end
		end

		// The lines show the level held at the start of this tick.
		res.scl     = scl_d;
		res.sda_out = sda_d;

		if (phase_d != PH_IDLE) begin
			res.busy_res = 1'b1;
			tick_d = tick_d + 16'd1;
			if (tick_d >= slot) begin
				unique case (phase_d)
					PH_ST_A: begin
						go = 1'b1; go_phase = PH_ST_B; go_scl = 1'b1; go_sda = 1'b0;
					end
					PH_ST_B: begin
						shift_d = mode_d[1] ? cfg.read_address_byte : cfg.write_address_byte;
						bit_count_d = '0;
						go = 1'b1; go_phase = PH_TX1_LO; go_scl = 1'b0; go_sda = shift_d[7];
					end
					PH_TX1_LO: begin
						go = 1'b1; go_phase = PH_TX1_HI; go_scl = 1'b1; go_sda = sda_d;
					end
					PH_TX2_LO: begin
						go = 1'b1; go_phase = PH_TX2_HI; go_scl = 1'b1; go_sda = sda_d;
					end
					PH_TX1_HI, PH_TX2_HI: begin
						shift_d     = {shift_d[6:0], 1'b0};
						bit_count_d = bit_count_d + 4'd1;
						go     = 1'b1;
						go_scl = 1'b0;
						if (bit_count_d >= BITS_PER_BYTE) begin
							go_phase = (phase_d == PH_TX1_HI) ? PH_ACK1_LO : PH_ACK2_LO;
							go_sda   = 1'b1;
						end else begin
							go_phase = (phase_d == PH_TX1_HI) ? PH_TX1_LO : PH_TX2_LO;
							go_sda   = shift_d[7];
						end
					end
					PH_ACK1_LO: begin
						go = 1'b1; go_phase = PH_ACK1_HI; go_scl = 1'b1; go_sda = 1'b1;
					end
					PH_ACK2_LO: begin
						go = 1'b1; go_phase = PH_ACK2_HI; go_scl = 1'b1; go_sda = 1'b1;
					end
					PH_ACK1_HI: begin
						bit_count_d = '0;
						go     = 1'b1;
						go_scl = 1'b0;
						if (cmd.sda_in) begin
							go_phase = PH_ABORT;
							go_sda   = 1'b1;
						end else if (!mode_d[1]) begin
							shift_d  = pending_d;
							go_phase = PH_TX2_LO;
							go_sda   = shift_d[7];
						end else begin
							shift_d  = '0;
							go_phase = PH_RX_LO;
							go_sda   = 1'b1;
						end
					end
					PH_ACK2_HI: begin
						go     = 1'b1;
						go_scl = 1'b0;
						if (cmd.sda_in) begin
							go_phase = PH_ABORT;
							go_sda   = 1'b1;
						end else begin
							go_phase = PH_SP_A;
							go_sda   = 1'b0;
						end
					end
					PH_RX_LO: begin
						go = 1'b1; go_phase = PH_RX_HI; go_scl = 1'b1; go_sda = 1'b1;
					end
					PH_RX_HI: begin
						shift_d     = {shift_d[6:0], cmd.sda_in};
						bit_count_d = bit_count_d + 4'd1;
						go     = 1'b1;
						go_scl = 1'b0;
						go_sda = 1'b1;
						go_phase = (bit_count_d >= BITS_PER_BYTE) ? PH_MACK_LO : PH_RX_LO;
					end
					PH_MACK_LO: begin
						go = 1'b1; go_phase = PH_MACK_HI; go_scl = 1'b1; go_sda = 1'b1;
					end
					PH_MACK_HI: begin
						go = 1'b1; go_phase = PH_SP_A; go_scl = 1'b0; go_sda = 1'b0;
					end
					PH_SP_A: begin
						go = 1'b1; go_phase = PH_SP_B; go_scl = 1'b1; go_sda = 1'b0;
					end
					PH_SP_B: begin
						go = 1'b1; go_phase = PH_SP_C; go_scl = 1'b1; go_sda = 1'b1;
					end
					PH_ABORT: begin
						finish = 1'b1;
						fail   = 1'b1;
					end
					default: begin
						finish = 1'b1;
					end
				endcase

				if (go) begin
					phase_d = go_phase;
					scl_d   = go_scl;
					sda_d   = go_sda;
					tick_d  = '0;
				end

				if (finish) begin
					phase_d      = PH_IDLE;
					tick_d       = '0;
					res.done_res = 1'b1;
					res.ack_fail = fail;
					if (mode_d[1]) begin
						// A failed read reports the shadow instead of the bus byte.
						if (!fail) begin
							shadow_d = shift_d;
						end
						res.read_value = shadow_d;
						if (mode_d == MODE_READ_PIN) begin
							res.pin_value = shadow_d[pin_d];
						end
					end else if (!fail) begin
						shadow_d = pending_d;
					end
				end
			end
		end

		res.port_image = shadow_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_q    <= SHADOW_RESET;
			phase_q     <= PH_IDLE;
			bit_count_q <= '0;
			shift_q     <= '0;
			tick_q      <= '0;
			mode_q      <= MODE_WRITE_ALL;
			pin_q       <= '0;
			pending_q   <= '0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
		end else if (step_en) begin
			shadow_q    <= shadow_d;
			phase_q     <= phase_d;
			bit_count_q <= bit_count_d;
			shift_q     <= shift_d;
			tick_q      <= tick_d;
			mode_q      <= mode_d;
			pin_q       <= pin_d;
			pending_q   <= pending_d;
			scl_q       <= scl_d;
			sda_q       <= sda_d;
		end
	end

endmodule

// File: hw/rtl/i2c_io_expander_port_master.sv
`timescale 1ns / 1ps
// A word accepted on cmd passes the input register cmd_s1 and then the result register res_s2 before it shows on res.
// Throughput: one word per cycle while res is not stalled; each cmd word is one tick of the bus sequencer,
// whose state update is a single pass between the input and result registers.
// Reset: arst_n is asynchronous; it empties both stages, idles the sequencer with
// both lines released, sets the shadow port to 0xFF and loads the register defaults.
module i2c_io_expander_port_master
	import i2cx_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	i2cx_stream_if.sink           cmd,
	i2cx_stream_if.source         res
);

	cfg_t      cfg;
	cmd_item_t cmd_s1;
	logic      valid_s1;
	res_item_t res_s2;
	logic      valid_s2;
	res_item_t step_res;
	logic      step_en;

	// A tick is applied when the result register is free or being drained.
	assign step_en   = valid_s1 && (!valid_s2 || res.ready);
	assign cmd.ready = !valid_s1 || step_en;

	i2cx_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	i2cx_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step_en),
		.cfg     (cfg),
		.cmd     (cmd_s1),
		.res     (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			cmd_s1 <= cmd.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (step_en) begin
			valid_s2 <= 1'b1;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			res_s2 <= step_res;
		end
	end

	assign res.valid = valid_s2;
	assign res.data  = res_s2;

endmodule

// File: verif/i2cx_bus_checker.sv
`timescale 1ns / 1ps

module i2cx_bus_checker
	import i2cx_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  cmd_valid,
	input  logic                  cmd_ready,
	input  cmd_item_t             cmd_data,
	input  logic                  res_valid,
	input  logic                  res_ready,
	input  res_item_t             res_data,
	output int                    errors,
	output int                    pending,
	output phase_t                seq_phase
);

	localparam int MAX_SHOWN = 10;

	logic [7:0]  wr_addr;
	logic [7:0]  rd_addr;
	logic [15:0] slot_len;
	logic [7:0]  shadow;
	logic [3:0]  nbits;
	logic [7:0]  shreg;
	logic [15:0] ticks;
	mode_t       amode;
	logic [2:0]  apin;
	logic [7:0]  pend;
	logic        scl_q;
	logic        sda_q;
	res_item_t   tick_results_due[$];
	res_item_t   want;
	string       field_diff;

	function automatic void move_to(phase_t p, logic c, logic d);
		seq_phase = p;
		scl_q     = c;
		sda_q     = d;
		ticks     = '0;
	endfunction

	function automatic logic reading();
		return amode == MODE_READ_ALL || amode == MODE_READ_PIN;
	endfunction

	// Advances the bus sequencer by one tick and returns the word it shows for that tick.
	function automatic res_item_t step_sequencer(cmd_item_t w);
		res_item_t   r;
		logic [16:0] limit;
		logic        finish;
		logic        nacked;
		r      = '0;
		finish = 1'b0;
		nacked = 1'b0;
		limit  = (slot_len == '0) ? 17'd1 : {1'b0, slot_len};

		if (seq_phase == PH_IDLE && w.cmd_valid) begin
			case (mode_t'(w.mode))
				MODE_WRITE_ALL: begin
					amode = MODE_WRITE_ALL;
					apin  = '0;
					pend  = w.write_byte;
					move_to(PH_ST_A, 1'b1, 1'b1);
				end
				MODE_SET_PIN: begin
					if (w.pin_index <= PIN_MAX) begin
						shadow[w.pin_index[2:0]] = w.pin_level;
						amode = MODE_SET_PIN;
						apin  = w.pin_index[2:0];
						pend  = shadow;
						move_to(PH_ST_A, 1'b1, 1'b1);
					end
				end
				MODE_READ_ALL: begin
					amode = MODE_READ_ALL;
					apin  = '0;
					move_to(PH_ST_A, 1'b1, 1'b1);
				end
				default: begin
					if (w.pin_index <= PIN_MAX) begin
						amode = MODE_READ_PIN;
						apin  = w.pin_index[2:0];
						move_to(PH_ST_A, 1'b1, 1'b1);
					end else begin
						r.done_res = 1'b1;
					end
				end
			endcase
		end

		r.scl     = scl_q;
		r.sda_out = sda_q;

		if (seq_phase != PH_IDLE) begin
			r.busy_res = 1'b1;
			ticks = ticks + 16'd1;
			if ({1'b0, ticks} >= limit) begin
				case (seq_phase)
					PH_ST_A: move_to(PH_ST_B, 1'b1, 1'b0);
					PH_ST_B: begin
						shreg = reading() ? rd_addr : wr_addr;
						nbits = '0;
						move_to(PH_TX1_LO, 1'b0, shreg[7]);
					end
					PH_TX1_LO: move_to(PH_TX1_HI, 1'b1, sda_q);
					PH_TX2_LO: move_to(PH_TX2_HI, 1'b1, sda_q);
					PH_TX1_HI, PH_TX2_HI: begin
						shreg = shreg << 1;
						nbits = nbits + 4'd1;
						if (nbits >= BITS_PER_BYTE)
							move_to(phase_t'(seq_phase == PH_TX1_HI ? PH_ACK1_LO : PH_ACK2_LO),
								1'b0, 1'b1);
						else
							move_to(phase_t'(seq_phase == PH_TX1_HI ? PH_TX1_LO : PH_TX2_LO),
								1'b0, shreg[7]);
					end
					PH_ACK1_LO: move_to(PH_ACK1_HI, 1'b1, 1'b1);
					PH_ACK2_LO: move_to(PH_ACK2_HI, 1'b1, 1'b1);
					PH_ACK1_HI: begin
						nbits = '0;
						if (w.sda_in) begin
							move_to(PH_ABORT, 1'b0, 1'b1);
						end else if (!reading()) begin
							shreg = pend;
							move_to(PH_TX2_LO, 1'b0, shreg[7]);
						end else begin
							shreg = '0;
							move_to(PH_RX_LO, 1'b0, 1'b1);
						end
					end
					PH_ACK2_HI: begin
						if (w.sda_in) move_to(PH_ABORT, 1'b0, 1'b1);
						else move_to(PH_SP_A, 1'b0, 1'b0);
					end
					PH_RX_LO: move_to(PH_RX_HI, 1'b1, 1'b1);
					PH_RX_HI: begin
						shreg = {shreg[6:0], w.sda_in};
						nbits = nbits + 4'd1;
						if (nbits >= BITS_PER_BYTE) move_to(PH_MACK_LO, 1'b0, 1'b1);
						else move_to(PH_RX_LO, 1'b0, 1'b1);
					end
					PH_MACK_LO: move_to(PH_MACK_HI, 1'b1, 1'b1);
					PH_MACK_HI: move_to(PH_SP_A, 1'b0, 1'b0);
					PH_SP_A:    move_to(PH_SP_B, 1'b1, 1'b0);
					PH_SP_B:    move_to(PH_SP_C, 1'b1, 1'b1);
					PH_ABORT: begin
						finish = 1'b1;
						nacked = 1'b1;
					end
					default: finish = 1'b1;
				endcase

				if (finish) begin
					seq_phase  = PH_IDLE;
					ticks      = '0;
					r.done_res = 1'b1;
					r.ack_fail = nacked;
					// A failed read leaves the shadow alone and reports it instead.
					if (reading()) begin
						if (!nacked) shadow = shreg;
						r.read_value = shadow;
						if (amode == MODE_READ_PIN) r.pin_value = shadow[apin];
					end else if (!nacked) begin
						shadow = pend;
					end
				end
			end
		end

		r.port_image = shadow;
		return r;
	endfunction

	function automatic string show(res_item_t r);
		return $sformatf("scl=%0b sda=%0b busy=%0b done=%0b nack=%0b read=%02h pin=%0b port=%02h",
			r.scl, r.sda_out, r.busy_res, r.done_res, r.ack_fail, r.read_value,
			r.pin_value, r.port_image);
	endfunction

	function automatic string differing_fields(res_item_t e, res_item_t a);
		string s;
		s = "";
		if (e.scl !== a.scl)               s = {s, " scl"};
		if (e.sda_out !== a.sda_out)       s = {s, " sda_out"};
		if (e.busy_res !== a.busy_res)     s = {s, " busy_res"};
		if (e.done_res !== a.done_res)     s = {s, " done_res"};
		if (e.ack_fail !== a.ack_fail)     s = {s, " ack_fail"};
		if (e.read_value !== a.read_value) s = {s, " read_value"};
		if (e.pin_value !== a.pin_value)   s = {s, " pin_value"};
		if (e.port_image !== a.port_image) s = {s, " port_image"};
		return s;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_addr    = WR_ADDR_RESET;
			rd_addr    = RD_ADDR_RESET;
			slot_len   = DELAY_RESET;
			shadow     = SHADOW_RESET;
			seq_phase  = PH_IDLE;
			nbits      = '0;
			shreg      = '0;
			ticks      = '0;
			amode      = MODE_WRITE_ALL;
			apin       = '0;
			pend       = '0;
			scl_q      = 1'b1;
			sda_q      = 1'b1;
			errors     = 0;
			tick_results_due.delete();
		end else begin
			if (cfg_wr_en) begin
				case (cfg_reg_t'(cfg_index))
					CFG_WR_ADDR: wr_addr  = cfg_wdata[7:0];
					CFG_RD_ADDR: rd_addr  = cfg_wdata[7:0];
					CFG_DELAY:   slot_len = cfg_wdata;
					default: ;
				endcase
			end

			if (res_valid && res_ready) begin
				if (tick_results_due.size() == 0) begin
					errors++;
					if (errors <= MAX_SHOWN)
						$display("%0t: result word with none expected: %s", $time, show(res_data));
				end else begin
					want = tick_results_due.pop_front();
					field_diff = differing_fields(want, res_data);
					if (field_diff != "") begin
						errors++;
						if (errors <= MAX_SHOWN)
							$display("%0t: result word differs in%s\n  expected %s\n  actual   %s",
								$time, field_diff, show(want), show(res_data));
					end
				end
			end

			if (cmd_valid && cmd_ready) begin
				tick_results_due.push_back(step_sequencer(cmd_data));
			end
		end
		pending = tick_results_due.size();
	end

endmodule

// File: verif/tb_i2c_io_expander_port_master.sv
`timescale 1ns / 1ps

module tb_i2c_io_expander_port_master;
	import i2cx_pkg::*;

	typedef enum logic [1:0] {
		FLOW_FREE,
		FLOW_SRC_IDLE,
		FLOW_SNK_STALL,
		FLOW_BOTH
	} flow_t;

	localparam int          HOLD_CYCLES  = 80;
	localparam int          DRAIN_CYCLES = 6;
	localparam int unsigned RUN_LIMIT_NS = 2_000_000;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	flow_t                 flow = FLOW_FREE;
	logic                  holding;
	int unsigned           nack1_pct;
	int unsigned           nack2_pct;
	logic                  rx_level;
	logic                  rx_random;
	int                    chk_errors;
	int                    chk_pending;
	phase_t                seq_phase;
	event                  hold_go;

	i2cx_stream_if #(.item_t(cmd_item_t)) cmd_if ();
	i2cx_stream_if #(.item_t(res_item_t)) res_if ();

	always #2 clk = ~clk;

	i2c_io_expander_port_master DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd_if),
		.res       (res_if)
	);

	i2cx_bus_checker bus_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.cmd_valid  (cmd_if.valid),
		.cmd_ready  (cmd_if.ready),
		.cmd_data   (cmd_if.data),
		.res_valid  (res_if.valid),
		.res_ready  (res_if.ready),
		.res_data   (res_if.data),
		.errors     (chk_errors),
		.pending    (chk_pending),
		.seq_phase  (seq_phase)
	);

	initial begin
		#(RUN_LIMIT_NS);
		$display("i2c_io_expander_port_master: mismatch");
		$finish;
	end

	// Long receiver hold-off, counted here so the sender keeps pushing meanwhile.
	initial begin
		holding = 1'b0;
		forever begin
			@(hold_go);
			holding <= 1'b1;
			repeat (HOLD_CYCLES) @(negedge clk);
			holding <= 1'b0;
		end
	end

	function automatic bit sender_rests();
		case (flow)
			FLOW_SRC_IDLE: return $urandom_range(99) < 69;
			FLOW_BOTH:     return $urandom_range(99) < 21;
			default:       return 1'b0;
		endcase
	endfunction

	function automatic bit receiver_stalls();
		case (flow)
			FLOW_SNK_STALL: return $urandom_range(99) < 69;
			FLOW_BOTH:      return $urandom_range(99) < 21;
			default:        return 1'b0;
		endcase
	endfunction

	initial begin
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			res_if.ready <= !holding && !receiver_stalls();
		end
	end

	// The data line level is picked from the sequencer phase the next word will meet,
	// so that acknowledge slots mostly pass and received bits follow the chosen pattern.
	function automatic cmd_item_t make_word(logic v, logic [1:0] m, logic [7:0] p, logic l,
		logic [7:0] b);
		cmd_item_t w;
		w.cmd_valid  = v;
		w.mode       = m;
		w.pin_index  = p;
		w.pin_level  = l;
		w.write_byte = b;
		case (seq_phase)
			PH_ACK1_HI: w.sda_in = $urandom_range(99) < nack1_pct;
			PH_ACK2_HI: w.sda_in = $urandom_range(99) < nack2_pct;
			PH_RX_HI:   w.sda_in = rx_random ? 1'($urandom_range(1)) : rx_level;
			default:    w.sda_in = 1'($urandom_range(1));
		endcase
		return w;
	endfunction

	function automatic cmd_item_t random_word(logic v);
		logic [7:0] p;
		p = ($urandom_range(99) < 85) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
		return make_word(v, 2'($urandom_range(3)), p, 1'($urandom_range(1)),
			8'($urandom_range(255)));
	endfunction

	task automatic offer_tick(input cmd_item_t w);
		while (sender_rests()) begin
			cmd_if.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_if.valid <= 1'b1;
		cmd_if.data  <= w;
		do @(posedge clk); while (!cmd_if.ready);
		@(negedge clk);
	endtask

	task automatic quiesce();
		cmd_if.valid <= 1'b0;
		@(negedge clk);
		wait (chk_pending == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_config(input logic [7:0] wa, input logic [7:0] ra,
		input logic [15:0] dl);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_WR_ADDR;
		cfg_wdata <= {8'($urandom_range(255)), wa};
		@(negedge clk);
		cfg_index <= CFG_RD_ADDR;
		cfg_wdata <= {8'($urandom_range(255)), ra};
		@(negedge clk);
		cfg_index <= CFG_DELAY;
		cfg_wdata <= dl;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Issues one command and keeps ticking until the sequencer is idle again.
	task automatic run_command(input mode_t m, input logic [7:0] p, input logic l,
		input logic [7:0] b, input bit noisy);
		offer_tick(make_word(1'b1, m, p, l, b));
		while (seq_phase != PH_IDLE)
			offer_tick(random_word(noisy ? 1'($urandom_range(1)) : 1'b0));
	endtask

	task automatic run_random_traffic(input int ticks);
		repeat (ticks)
			offer_tick(random_word(seq_phase == PH_IDLE ? ($urandom_range(99) < 30)
				: ($urandom_range(99) < 40)));
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_wr_en    = 1'b0;
		cfg_index    = '0;
		cfg_wdata    = '0;
		cmd_if.valid = 1'b0;
		cmd_if.data  = '0;
		nack1_pct    = 0;
		nack2_pct    = 0;
		rx_level     = 1'b0;
		rx_random    = 1'b0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// A write starts with the register defaults and crawls through its first slot,
		// then the slot is shortened while the START is still held. Commands offered
		// meanwhile must be dropped.
		offer_tick(make_word(1'b1, MODE_WRITE_ALL, 8'd0, 1'b0, 8'hA5));
		repeat (20) offer_tick(random_word(1'($urandom_range(1))));
		quiesce();
		set_config(8'hFF, 8'h00, 16'd1);
		while (seq_phase != PH_IDLE)
			offer_tick(random_word(1'($urandom_range(1))));

		run_command(MODE_SET_PIN, 8'd0, 1'b0, 8'h00, 1'b0);
		run_command(MODE_SET_PIN, 8'd8, 1'b0, 8'h00, 1'b0);
		run_command(MODE_SET_PIN, 8'd255, 1'b1, 8'h00, 1'b0);
		run_command(MODE_READ_ALL, 8'd0, 1'b0, 8'h00, 1'b0);
		rx_level = 1'b1;
		run_command(MODE_READ_PIN, 8'd7, 1'b0, 8'h00, 1'b0);
		rx_level = 1'b0;
		run_command(MODE_READ_PIN, 8'd8, 1'b0, 8'h00, 1'b0);
		run_command(MODE_READ_PIN, 8'd255, 1'b0, 8'h00, 1'b0);

		// Address not acknowledged: no STOP, a read reports the shadow.
		nack1_pct = 100;
		run_command(MODE_WRITE_ALL, 8'd0, 1'b0, 8'h3C, 1'b0);
		run_command(MODE_READ_PIN, 8'd5, 1'b0, 8'h00, 1'b0);
		nack1_pct = 0;
		nack2_pct = 100;
		run_command(MODE_SET_PIN, 8'd4, 1'b1, 8'h00, 1'b0);
		nack2_pct = 0;

		nack1_pct = 8;
		nack2_pct = 8;
		rx_random = 1'b1;

		quiesce();
		set_config(8'h40, 8'h41, 16'd1);
		flow = FLOW_FREE;
		-> hold_go;
		run_random_traffic(50);

		quiesce();
		set_config(8'h00, 8'hFF, 16'd2);
		flow = FLOW_SRC_IDLE;
		run_random_traffic(30);

		quiesce();
		set_config(8'hFF, 8'h00, 16'd0);
		flow = FLOW_SNK_STALL;
		run_random_traffic(30);

		quiesce();
		set_config(8'($urandom_range(255)), 8'($urandom_range(255)), 16'd3);
		flow = FLOW_BOTH;
		run_random_traffic(30);

		quiesce();
		if (chk_errors == 0 && chk_pending == 0)
			$display("i2c_io_expander_port_master: match");
		else
			$display("i2c_io_expander_port_master: mismatch");
		$finish;
	end

endmodule
